// ===== hw/rtl/lcgja_pkg.sv =====
// shared constants and types for the lcg jump-ahead block
package lcgja_pkg;

    localparam int SEED_W      = 31;
    localparam int STEP_W      = 63;
    localparam int VALUE_W     = 31;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;

    localparam int MULT_W      = 31;
    localparam int INCR_W      = 31;
    localparam int MOD_W       = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_VALUE_BITS = 31;
    localparam int DEF_STEP_BITS  = 63;

    localparam logic [CFG_ADDR_W-1:0] CFG_MULTIPLIER = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INCREMENT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODULUS    = 2'd2;

    localparam logic [MULT_W-1:0] MULT_RESET = 31'd1103515245;
    localparam logic [INCR_W-1:0] INCR_RESET = 31'd12345;
    localparam logic [MOD_W-1:0]  MOD_RESET  = 32'd2147483648;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_RED_SEED,
        OP_RED_A,
        OP_RED_C,
        OP_ACC_C,
        OP_ACC_A,
        OP_SQR_C,
        OP_SQR_A,
        OP_FINAL
    } t_op;

endpackage

// ===== hw/rtl/lcg_jump_ahead_top.sv =====
// lcg jump-ahead: sequenced square-and-multiply over one shared modular multiply-add unit
//
// input stream (s side): one transaction carries a seed and a step count; the result
// is the generator value after that many steps of x' = (a*x + c) mod m.
// output stream (m side): one transaction per input transaction, in order.
// config port: write multiplier, increment, modulus by index while the block is idle.
// all arithmetic goes through one modular multiply-add unit that scans one bit of its
// multiplier operand per cycle with a shift, an add and a two-way compare-subtract.
// each modular operation is an operand load followed by VALUE_BITS+1 scan steps; an item
// needs 4 + 2*popcount(step) + 2*msb_index(step) operations, 4 for a zero step count.
// one item is in flight at a time; s_tready is high only while the sequencer is idle.
// the finished value sits in an output register, so a stalled receiver holds one
// result while the next item is accepted; the sequencer waits only if a second result
// is ready before the first is taken.
// reset restores the default multiplier, increment and modulus and drops any result.
module lcg_jump_ahead_top #(
    parameter int VALUE_BITS = lcgja_pkg::DEF_VALUE_BITS,
    parameter int STEP_BITS  = lcgja_pkg::DEF_STEP_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [lcgja_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // seed[30:0], step_count[93:31]
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [lcgja_pkg::OUT_TDATA_W-1:0] o_m_tdata,   // value[30:0]
    input  logic                              i_cfg_we,
    input  logic [lcgja_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [lcgja_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import lcgja_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int SUM_W = VALUE_BITS + 2;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [MULT_W-1:0] r_mult;
    logic [INCR_W-1:0] r_incr;
    logic [MOD_W-1:0]  r_mod;

    logic [VALUE_BITS-1:0] r_seed, n_seed;
    logic [VALUE_BITS-1:0] r_ba, n_ba;
    logic [VALUE_BITS-1:0] r_bc, n_bc;
    logic [VALUE_BITS-1:0] r_aa, n_aa;
    logic [VALUE_BITS-1:0] r_ac, n_ac;
    logic [VALUE_BITS:0]   r_m, n_m;
    logic [STEP_BITS-1:0]  r_steps, n_steps;

    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0] r_mx, n_mx;
    logic [VALUE_BITS-1:0] r_my, n_my;
    logic [VALUE_BITS-1:0] r_mz, n_mz;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic                  r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0] r_out_value, n_out_value;

    logic [MOD_W:0]        w_full;
    logic [VALUE_BITS:0]   w_meff;
    logic [SUM_W-1:0]      w_dbl;
    logic [SUM_W-1:0]      w_add;
    logic [SUM_W-1:0]      w_sum;
    logic [SUM_W-1:0]      w_m1;
    logic [SUM_W-1:0]      w_m2;
    logic [SUM_W-1:0]      w_red;
    logic [VALUE_BITS-1:0] w_res;

    function automatic t_op f_bit_op(input logic [STEP_BITS-1:0] s);
        t_op op;
        if (s == '0) begin
            op = OP_FINAL;
        end else if (s[0]) begin
            op = OP_ACC_C;
        end else begin
            op = OP_SQR_C;
        end
        return op;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= MULT_RESET;
            r_incr <= INCR_RESET;
            r_mod  <= MOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MULTIPLIER: r_mult <= i_cfg_wdata[MULT_W-1:0];
                CFG_INCREMENT:  r_incr <= i_cfg_wdata[INCR_W-1:0];
                CFG_MODULUS:    r_mod  <= i_cfg_wdata[MOD_W-1:0];
                default: ;
            endcase
        end
    end

    // effective modulus: zero or above full range wraps at 2^VALUE_BITS
    always_comb begin
        w_full = {{MOD_W{1'b0}}, 1'b1} << VALUE_BITS;
        if (r_mod == '0 || {1'b0, r_mod} > w_full) begin
            w_meff = w_full[VALUE_BITS:0];
        end else begin
            w_meff = r_mod[VALUE_BITS:0];
        end
    end

    // shared modular multiply-add step
    always_comb begin
        if (r_cnt != '0) begin
            w_dbl = {1'b0, r_acc, 1'b0};
            w_add = r_my[VALUE_BITS-1] ? {2'b00, r_mx} : '0;
        end else begin
            w_dbl = {2'b00, r_acc};
            w_add = {2'b00, r_mz};
        end
        w_sum = w_dbl + w_add;
        w_m1  = {1'b0, r_m};
        w_m2  = {r_m, 1'b0};
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
        w_res = w_red[VALUE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_seed      <= n_seed;
        r_ba        <= n_ba;
        r_bc        <= n_bc;
        r_aa        <= n_aa;
        r_ac        <= n_ac;
        r_m         <= n_m;
        r_steps     <= n_steps;
        r_acc       <= n_acc;
        r_mx        <= n_mx;
        r_my        <= n_my;
        r_mz        <= n_mz;
        r_cnt       <= n_cnt;
        r_out_value <= n_out_value;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_seed      = r_seed;
        n_ba        = r_ba;
        n_bc        = r_bc;
        n_aa        = r_aa;
        n_ac        = r_ac;
        n_m         = r_m;
        n_steps     = r_steps;
        n_acc       = r_acc;
        n_mx        = r_mx;
        n_my        = r_my;
        n_mz        = r_mz;
        n_cnt       = r_cnt;
        n_out_value = r_out_value;
        n_out_valid = r_out_valid & ~i_m_tready;
        o_s_tready  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_seed  = i_s_tdata[VALUE_BITS-1:0];
                    n_steps = i_s_tdata[SEED_W +: STEP_BITS];
                    n_ba    = r_mult[VALUE_BITS-1:0];
                    n_bc    = r_incr[VALUE_BITS-1:0];
                    n_m     = w_meff;
                    n_aa    = (w_meff == (VALUE_BITS+1)'(1)) ? '0 : VALUE_BITS'(1);
                    n_ac    = '0;
                    n_op    = OP_RED_SEED;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_acc   = '0;
                n_cnt   = CNT_W'(VALUE_BITS);
                n_state = ST_RUN;
                unique case (r_op)
                    OP_RED_SEED: begin
                        n_mx = VALUE_BITS'(1);
                        n_my = r_seed;
                        n_mz = '0;
                    end
                    OP_RED_A: begin
                        n_mx = VALUE_BITS'(1);
                        n_my = r_ba;
                        n_mz = '0;
                    end
                    OP_RED_C: begin
                        n_mx = VALUE_BITS'(1);
                        n_my = r_bc;
                        n_mz = '0;
                    end
                    OP_ACC_C: begin
                        n_mx = r_aa;
                        n_my = r_bc;
                        n_mz = r_ac;
                    end
                    OP_ACC_A: begin
                        n_mx = r_aa;
                        n_my = r_ba;
                        n_mz = '0;
                    end
                    OP_SQR_C: begin
                        n_mx = r_ba;
                        n_my = r_bc;
                        n_mz = r_bc;
                    end
                    OP_SQR_A: begin
                        n_mx = r_ba;
                        n_my = r_ba;
                        n_mz = '0;
                    end
                    OP_FINAL: begin
                        n_mx = r_aa;
                        n_my = r_seed;
                        n_mz = r_ac;
                    end
                    default: ;
                endcase
            end
            ST_RUN: begin
                n_acc = w_res;
                n_my  = r_my << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_LOAD;
                    unique case (r_op)
                        OP_RED_SEED: begin
                            n_seed = w_res;
                            n_op   = OP_RED_A;
                        end
                        OP_RED_A: begin
                            n_ba = w_res;
                            n_op = OP_RED_C;
                        end
                        OP_RED_C: begin
                            n_bc = w_res;
                            n_op = f_bit_op(r_steps);
                        end
                        OP_ACC_C: begin
                            n_ac = w_res;
                            n_op = OP_ACC_A;
                        end
                        OP_ACC_A: begin
                            n_aa = w_res;
                            n_op = ((r_steps >> 1) == '0) ? OP_FINAL : OP_SQR_C;
                        end
                        OP_SQR_C: begin
                            n_bc = w_res;
                            n_op = OP_SQR_A;
                        end
                        OP_SQR_A: begin
                            n_ba    = w_res;
                            n_steps = r_steps >> 1;
                            n_op    = f_bit_op(r_steps >> 1);
                        end
                        OP_FINAL: begin
                            n_seed  = w_res;
                            n_state = ST_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_seed;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_value);

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside done state");

    a_acc_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> {1'b0, r_acc} < r_m)
        else $error("unit accumulator not reduced");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_cnt <= CNT_W'(VALUE_BITS))
        else $error("scan counter out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_state == ST_LOAD && r_op == OP_RED_SEED)
        else $error("accepted transaction did not start the sequence");

endmodule
